>>> hdl/ptr_pkg.sv
// shared types and constants for the packet trace ring
// used by the front end, the event queue, the ring back end and the top level
`timescale 1ns / 1ps
`default_nettype none

package ptr_pkg;

  localparam int unsigned DefRecords  = 10;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned InDataW     = 184;
  localparam int unsigned OutDataW    = 248;
  localparam int unsigned RstFlagBit  = 2;

  // one IPv4 header event as it travels from the front end to the ring
  typedef struct packed {
    logic        is_rst;
    logic        is_send;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] total_len;
    logic [5:0]  ip_hdr;
    logic [5:0]  tcp_hdr;
    logic [15:0] window;
    logic [7:0]  flags;
    logic [63:0] stamp;
  } evt_t;

  // one dumped record with the counters
  typedef struct packed {
    logic        is_send;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] payload_len;
    logic [15:0] window;
    logic [5:0]  ip_hdr;
    logic [5:0]  tcp_hdr;
    logic [7:0]  flags;
    logic [63:0] stamp;
    logic [31:0] sent_cnt;
    logic [31:0] recv_cnt;
  } rec_t;

endpackage

`default_nettype wire

>>> hdl/packet_trace_ring_with_reset_dump.sv
// Traces TCP/IPv4 header events into a ring of RECORDS entries and dumps the
// ring oldest first on every RST segment. A beat without RST is written to the
// ring in the back end's idle state; a RST beat keeps the back end busy until
// every stored record (at most RECORDS, the RST event among them) has been read
// from the ring memory and then sent, held while the output is stalled. A
// two-entry event queue keeps taking beats during a dump until it holds two,
// then the input stalls until the dump ends; IPv6 beats are accepted and
// dropped but also wait while the queue is full.
// Counters wrap at 32 bits.
// top level: front end, event queue and ring back end; depends on ptr_pkg
`timescale 1ns / 1ps
`default_nettype none

module packet_trace_ring_with_reset_dump #(
  parameter int unsigned RECORDS = ptr_pkg::DefRecords
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // is_send, seq_number, ack_number, ip_total_length, ip_header_bytes,
  // tcp_header_bytes, window_size, tcp_flags, timestamp, zero pad
  input  wire logic [ptr_pkg::InDataW-1:0]   s_axis_tdata,
  // is_ipv6
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // rec_is_send, rec_seq, rec_ack, payload_length, rec_window, rec_ip_header,
  // rec_tcp_header, rec_flags, rec_time, sent_count, received_count, zero pad
  output logic [ptr_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast
);
  import ptr_pkg::*;

  evt_t push_item, q_item;
  rec_t rec;
  logic q_ready, q_push, q_valid, q_pop;

  ptr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  ptr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  ptr_back #(
    .RECORDS (RECORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .rec_valid_o (m_axis_tvalid),
    .rec_ready_i (m_axis_tready),
    .rec_o       (rec),
    .rec_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, rec.recv_cnt, rec.sent_cnt, rec.stamp, rec.flags,
                         rec.tcp_hdr, rec.ip_hdr, rec.window, rec.payload_len,
                         rec.ack, rec.seq, rec.is_send};

endmodule

`default_nettype wire

>>> hdl/ptr_front.sv
// front end: unpacks input beats, drops IPv6 events, marks RST events
// depends on ptr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptr_front (
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [ptr_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                         s_axis_tuser,
  input  wire logic                         q_ready_i,
  output logic                              q_push_o,
  output ptr_pkg::evt_t                     q_item_o
);
  import ptr_pkg::*;

  always_comb begin
    q_item_o.is_send   = s_axis_tdata[0];
    q_item_o.seq       = s_axis_tdata[32:1];
    q_item_o.ack       = s_axis_tdata[64:33];
    q_item_o.total_len = s_axis_tdata[80:65];
    q_item_o.ip_hdr    = s_axis_tdata[86:81];
    q_item_o.tcp_hdr   = s_axis_tdata[92:87];
    q_item_o.window    = s_axis_tdata[108:93];
    q_item_o.flags     = s_axis_tdata[116:109];
    q_item_o.stamp     = s_axis_tdata[180:117];
    q_item_o.is_rst    = s_axis_tdata[109 + RstFlagBit];
  end

  // ipv6 beats are taken and dropped here
  assign s_axis_tready = q_ready_i;
  assign q_push_o      = s_axis_tvalid && q_ready_i && !s_axis_tuser;

endmodule

`default_nettype wire

>>> hdl/ptr_queue.sv
// short event queue between the front end and the ring back end
// depends on ptr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptr_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire ptr_pkg::evt_t push_item_i,
  output logic         ready_o,
  output logic         valid_o,
  output ptr_pkg::evt_t item_o,
  input  wire logic    pop_i
);
  import ptr_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);

  evt_t            slot_q [QueueDepth];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + IdxW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + IdxW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ptr_back.sv
// ring back end: counters, ring memory and the dump sequencer
// depends on ptr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptr_back #(
  parameter int unsigned RECORDS = ptr_pkg::DefRecords
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire ptr_pkg::evt_t q_item_i,
  output logic         q_pop_o,
  output logic         rec_valid_o,
  input  wire logic    rec_ready_i,
  output ptr_pkg::rec_t rec_o,
  output logic         rec_last_o
);
  import ptr_pkg::*;

  localparam int unsigned PtrW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int unsigned CntW = $clog2(RECORDS + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(RECORDS - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  logic [1:0]      state_q;
  logic [PtrW-1:0] wp_q, rd_ptr_q, wp_next, rd_next;
  logic            full_q;
  logic [CntW-1:0] left_q;
  logic [31:0]     sent_q, recv_q;
  evt_t            rd_q;
  evt_t            ring_mem [RECORDS];

  assign wp_next = (wp_q == LastSlot) ? '0 : wp_q + PtrW'(1);
  assign rd_next = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + PtrW'(1);
  assign q_pop_o = (state_q == StIdle) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wp_q     <= '0;
      rd_ptr_q <= '0;
      full_q   <= 1'b0;
      left_q   <= '0;
      sent_q   <= '0;
      recv_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            if (q_item_i.is_send) begin
              sent_q <= sent_q + 32'd1;
            end else begin
              recv_q <= recv_q + 32'd1;
            end
            if (q_item_i.is_rst) begin
              // full ring starts one past the newest slot, else at slot zero
              rd_ptr_q <= full_q ? wp_next : '0;
              left_q   <= full_q ? CntW'(RECORDS) : CntW'(wp_q) + CntW'(1);
              state_q  <= StRead;
            end else begin
              wp_q   <= wp_next;
              full_q <= full_q || (wp_q == LastSlot);
            end
          end
        end
        StRead: begin
          state_q <= StSend;
        end
        StSend: begin
          if (rec_ready_i) begin
            left_q <= left_q - CntW'(1);
            if (left_q == CntW'(1)) begin
              wp_q    <= wp_next;
              full_q  <= full_q || (wp_q == LastSlot);
              state_q <= StIdle;
            end else begin
              rd_ptr_q <= rd_next;
              state_q  <= StRead;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ring_mem[wp_q] <= q_item_i;
    end
    if (state_q == StRead) begin
      rd_q <= ring_mem[rd_ptr_q];
    end
  end

  assign rec_valid_o = (state_q == StSend);
  assign rec_last_o  = (left_q == CntW'(1));

  always_comb begin
    rec_o.is_send     = rd_q.is_send;
    rec_o.seq         = rd_q.seq;
    rec_o.ack         = rd_q.ack;
    rec_o.payload_len = rd_q.total_len - {10'd0, rd_q.ip_hdr} - {10'd0, rd_q.tcp_hdr};
    rec_o.window      = rd_q.window;
    rec_o.ip_hdr      = rd_q.ip_hdr;
    rec_o.tcp_hdr     = rd_q.tcp_hdr;
    rec_o.flags       = rd_q.flags;
    rec_o.stamp       = rd_q.stamp;
    rec_o.sent_cnt    = sent_q;
    rec_o.recv_cnt    = recv_q;
  end

endmodule

`default_nettype wire
